FILE: rtl/wpm_pkg.sv
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared types, constants and the star-run prefix function of the
// wildcard pattern matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package wpm_pkg;

  localparam int PATTERN_MAX = 32;
  localparam int COL_W       = PATTERN_MAX + 1;
  localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
  localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int LVL_N       = $clog2(COL_W);

  localparam logic [7:0] STAR_CODE = 8'd42;
  localparam logic [7:0] ANY_CODE  = 8'd63;

  typedef enum logic {
    REQ_PATTERN = 1'b0,
    REQ_TEXT    = 1'b1
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] symbol;
    logic       first;
  } req_t;

  typedef struct packed {
    logic valid;
    req_t req;
  } head_t;

  // out[i] = g[i] | p[i] & out[i-1], as a log-depth prefix network
  function automatic logic [COL_W-1:0] chain_or(input logic [COL_W-1:0] g_in,
                                                input logic [COL_W-1:0] p_in);
    logic [COL_W-1:0] g;
    logic [COL_W-1:0] p;
    logic [COL_W-1:0] gn;
    logic [COL_W-1:0] pn;
    g = g_in;
    p = p_in;
    for (int k = 0; k < LVL_N; k++) begin
      gn = g;
      pn = p;
      for (int i = 0; i < COL_W; i++) begin
        if (i >= (1 << k)) begin
          gn[i] = g[i] | (p[i] & g[i - (1 << k)]);
          pn[i] = p[i] & p[i - (1 << k)];
        end
      end
      g = gn;
      p = pn;
    end
    return g;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/wpm_front.sv
// ----------------------------------------------------------------------------
// wpm_front
// Request intake: accepts words and holds them in a two-entry queue
// ahead of the matching engine.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire logic          req_type,
  input  wire logic [7:0]    symbol,
  input  wire logic          first,
  output wpm_pkg::head_t     head,
  input  wire logic          head_stall
);

  wpm_pkg::req_t slot [2];
  logic [1:0]    count;
  logic          wr_ptr;
  logic          rd_ptr;
  logic          push;
  logic          pop;

  assign req_stall  = (count == 2'd2);
  assign push       = req_valid & ~req_stall;
  assign head       = '{valid: (count != 2'd0), req: slot[rd_ptr]};
  assign pop        = head.valid & ~head_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{kind: wpm_pkg::req_kind_t'(req_type), symbol: symbol, first: first};
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wpm_back.sv
// ----------------------------------------------------------------------------
// wpm_back
// Matching engine: pattern store, match column update and the
// registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module wpm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire wpm_pkg::head_t head,
  output logic               head_stall,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output logic               matched,
  output logic               overflow
);

  logic [7:0]                   pat [wpm_pkg::PATTERN_MAX];
  logic [wpm_pkg::COL_W-1:0]    col;
  logic [wpm_pkg::COL_W-1:0]    col_next;
  logic [wpm_pkg::COL_W-1:0]    empty_col;
  logic [wpm_pkg::COL_W-1:0]    empty_col_next;
  logic [wpm_pkg::LEN_W-1:0]    len;
  logic [wpm_pkg::LEN_W-1:0]    len_next;
  logic                         ovf;
  logic                         ovf_next;
  logic [wpm_pkg::LEN_W-1:0]    len_base;
  logic [wpm_pkg::COL_W-1:0]    empty_base;
  logic                         ovf_base;
  logic [wpm_pkg::COL_W-1:0]    base;
  logic [wpm_pkg::COL_W-1:0]    gen;
  logic [wpm_pkg::COL_W-1:0]    prop;
  logic                         new_pat;
  logic                         has_room;
  logic                         pop;
  logic                         is_star;
  logic                         pos_valid;

  assign head_stall = rsp_valid & rsp_stall;
  assign pop        = head.valid & ~head_stall;
  assign new_pat    = (head.req.kind == wpm_pkg::REQ_PATTERN) & head.req.first;
  assign len_base   = new_pat ? '0 : len;
  assign ovf_base   = new_pat ? 1'b0 : ovf;
  assign empty_base = new_pat ? wpm_pkg::COL_W'(1) : empty_col;
  assign has_room   = (len_base < wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX));

  // text step: diagonal on literal or '?', star runs through the prefix network
  always_comb begin
    base    = head.req.first ? empty_col : col;
    gen     = '0;
    prop    = '0;
    is_star = 1'b0;
    pos_valid = 1'b0;
    for (int i = 1; i < wpm_pkg::COL_W; i++) begin
      pos_valid = (wpm_pkg::LEN_W'(i) <= len);
      is_star   = (pat[i-1] == wpm_pkg::STAR_CODE);
      prop[i]   = pos_valid & is_star;
      gen[i]    = pos_valid & (is_star ? base[i]
                                       : base[i-1] & ((pat[i-1] == wpm_pkg::ANY_CODE) |
                                                      (pat[i-1] == head.req.symbol)));
    end
  end

  always_comb begin
    len_next       = len;
    ovf_next       = ovf;
    empty_col_next = empty_col;
    col_next       = col;
    unique case (head.req.kind)
      wpm_pkg::REQ_PATTERN: begin
        ovf_next       = ovf_base;
        len_next       = len_base;
        empty_col_next = empty_base;
        if (has_room) begin
          len_next       = len_base + wpm_pkg::LEN_W'(1);
          empty_col_next = empty_base |
                           (wpm_pkg::COL_W'(empty_base[len_base] &
                                            (head.req.symbol == wpm_pkg::STAR_CODE))
                            << len_next);
        end else begin
          ovf_next = 1'b1;
        end
        col_next = empty_col_next;
      end
      wpm_pkg::REQ_TEXT: begin
        col_next = wpm_pkg::chain_or(gen, prop);
      end
      default: begin
        col_next = col;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col       <= wpm_pkg::COL_W'(1);
      empty_col <= wpm_pkg::COL_W'(1);
      len       <= '0;
      ovf       <= 1'b0;
      rsp_valid <= 1'b0;
    end else if (pop) begin
      col       <= col_next;
      empty_col <= empty_col_next;
      len       <= len_next;
      ovf       <= ovf_next;
      rsp_valid <= 1'b1;
    end else if (~rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      matched  <= col_next[len_next] & ~ovf_next;
      overflow <= ovf_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop & (head.req.kind == wpm_pkg::REQ_PATTERN) & has_room) begin
      pat[len_base[wpm_pkg::IDX_W-1:0]] <= head.req.symbol;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/wildcard_pattern_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams pattern and text bytes and reports a wildcard match per word.
// ----------------------------------------------------------------------------
// Pattern words (req_type 0) append a byte to the stored pattern, up to 32
// bytes; first=1 starts a new pattern and clears the overflow flag. Text
// words (req_type 1) advance the match by one byte; first=1 starts a new text.
// '*' matches any run of bytes, '?' any one byte. Every word yields one
// result: matched (whole pattern against the text so far, the empty text after
// a pattern word) and the sticky overflow flag. The block takes one word per
// clock and gives one result per clock while results are not stalled; all
// pattern positions update in parallel via a log-depth prefix network over star
// runs. A word is held in the two-word queue, then its result is registered;
// the queue and the output register keep intake running while a result stalls.
`default_nettype none

module wildcard_pattern_matcher (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  output logic            req_stall,
  input  wire logic       req_type,
  input  wire logic [7:0] symbol,
  input  wire logic       first,
  output logic            rsp_valid,
  input  wire logic       rsp_stall,
  output logic            matched,
  output logic            overflow
);

  wpm_pkg::head_t head;
  logic           head_stall;

  wpm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req_type   (req_type),
    .symbol     (symbol),
    .first      (first),
    .head       (head),
    .head_stall (head_stall)
  );

  wpm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_stall (head_stall),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .matched    (matched),
    .overflow   (overflow)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives pattern and text words into the wildcard pattern matcher with random
// gaps on both sides and compares each result word with a model of the
// matching column. The model is updated when a word is accepted. It covers
// directed corner cases, random pattern/text sequences with some noise, and a
// long receiver hold-off that backs up the input side.
// ----------------------------------------------------------------------------

module testbench;
  import wpm_pkg::*;

  typedef struct packed {
    logic matched;
    logic overflow;
  } match_result_t;

  class match_scoreboard;
    logic [7:0]         pattern_bytes [PATTERN_MAX];
    int unsigned        pattern_len;
    bit [PATTERN_MAX:0] column;
    bit                 too_long;
    match_result_t      pending_results [$];
    int                 errors;

    function new();
      pattern_len = 0;
      column      = COL_W'(1);
      too_long    = 0;
      errors      = 0;
    endfunction

    // column for the empty text: leading run of stars
    function void reset_column();
      bit stars;
      stars  = 1;
      column = '0;
      column[0] = 1'b1;
      for (int i = 1; i <= PATTERN_MAX; i++) begin
        if (i <= pattern_len && stars && pattern_bytes[i-1] == STAR_CODE)
          column[i] = 1'b1;
        else
          stars = 0;
      end
    endfunction

    function void advance_column(logic [7:0] c);
      bit [PATTERN_MAX:0] nxt;
      nxt = '0;
      for (int i = 1; i <= pattern_len; i++) begin
        if (pattern_bytes[i-1] == STAR_CODE)
          nxt[i] = nxt[i-1] | column[i];
        else if (pattern_bytes[i-1] == ANY_CODE || pattern_bytes[i-1] == c)
          nxt[i] = column[i-1];
      end
      column = nxt;
    endfunction

    function void note_word(req_kind_t kind, logic [7:0] sym, logic fst);
      match_result_t res;
      if (kind == REQ_PATTERN) begin
        if (fst) begin
          pattern_len = 0;
          too_long    = 0;
        end
        if (pattern_len < PATTERN_MAX) begin
          pattern_bytes[pattern_len] = sym;
          pattern_len++;
        end else begin
          too_long = 1;
        end
        reset_column();
      end else begin
        if (fst)
          reset_column();
        advance_column(sym);
      end
      res.matched  = column[pattern_len] & ~too_long;
      res.overflow = too_long;
      pending_results.push_back(res);
    endfunction

    function void check_result(logic m, logic o);
      match_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word matched %b overflow %b", $time, m, o);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (m !== want.matched) begin
        $display("%0t: matched expected %b actual %b", $time, want.matched, m);
        errors++;
      end
      if (o !== want.overflow) begin
        $display("%0t: overflow expected %b actual %b", $time, want.overflow, o);
        errors++;
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_stall;
  logic       req_type;
  logic [7:0] symbol;
  logic       first;
  logic       rsp_valid;
  logic       rsp_stall;
  logic       matched;
  logic       overflow;

  match_scoreboard sb = new();
  int  words_sent = 0;
  bit  calm = 0;
  bit  hold_on = 0;

  wildcard_pattern_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_type  (req_type),
    .symbol    (symbol),
    .first     (first),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .matched   (matched),
    .overflow  (overflow)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(10, 30);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || hold_on || r < 55) return 0;
    return pick_len();
  endfunction

  task automatic send_word(input req_kind_t kind, input logic [7:0] sym, input logic fst);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid = 1'b1;
    req_type  = kind;
    symbol    = sym;
    first     = fst;
    forever begin
      @(posedge clk);
      if (!req_stall) break;
    end
    sb.note_word(kind, sym, fst);
    words_sent++;
  endtask

  function automatic logic [7:0] pattern_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return STAR_CODE;
    if (r < 45) return ANY_CODE;
    if (r < 85) return 8'(8'h61 + $urandom_range(0, 2));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'(8'h61 + $urandom_range(0, 2));
    if (r < 90) return STAR_CODE;
    if (r < 93) return ANY_CODE;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_random_sequence();
    int  r;
    int  plen;
    int  tlen;
    bit  fresh;
    calm = ($urandom_range(0, 4) == 0);
    r = $urandom_range(0, 99);
    if (r < 8) begin
      send_word(req_kind_t'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 70)      plen = $urandom_range(1, 6);
    else if (r < 93) plen = $urandom_range(7, 32);
    else             plen = $urandom_range(33, 36);
    fresh = ($urandom_range(0, 19) != 0);
    for (int i = 0; i < plen; i++)
      send_word(REQ_PATTERN, pattern_char(), (i == 0) && fresh);
    repeat ($urandom_range(1, 3)) begin
      tlen = $urandom_range(1, 12);
      fresh = ($urandom_range(0, 9) != 0);
      for (int j = 0; j < tlen; j++)
        send_word(REQ_TEXT, text_char(), (j == 0) && fresh);
    end
  endtask

  // receiver: random stall bursts with calm stretches
  initial begin
    int burst;
    int mode_left;
    bit rx_calm;
    burst     = 0;
    mode_left = 0;
    rx_calm   = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (mode_left == 0) begin
        rx_calm   = ($urandom_range(0, 3) == 0);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (burst == 0 && !rx_calm && $urandom_range(0, 3) == 0)
        burst = pick_len();
      rsp_stall = hold_on || (burst > 0);
      if (burst > 0) burst--;
    end
  end

  // long receiver hold-off while the sender keeps going
  initial begin
    wait (words_sent >= 300);
    @(posedge clk);
    hold_on = 1;
    repeat (100) @(posedge clk);
    hold_on = 0;
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall)
      sb.check_result(matched, overflow);
  end

  initial begin
    int waited;
    rst       = 1'b1;
    req_valid = 1'b0;
    req_type  = 1'b0;
    symbol    = 8'h00;
    first     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // text with no pattern loaded
    send_word(REQ_TEXT, 8'h61, 1'b0);
    // byte extremes as literals
    send_word(REQ_PATTERN, 8'h00, 1'b1);
    send_word(REQ_PATTERN, 8'hFF, 1'b0);
    send_word(REQ_TEXT, 8'h00, 1'b1);
    send_word(REQ_TEXT, 8'hFF, 1'b0);
    send_word(REQ_TEXT, 8'hFF, 1'b0);
    // star against star
    send_word(REQ_PATTERN, STAR_CODE, 1'b1);
    send_word(REQ_TEXT, STAR_CODE, 1'b1);
    send_word(REQ_TEXT, 8'h71, 1'b0);
    // a?*c
    send_word(REQ_PATTERN, 8'h61, 1'b1);
    send_word(REQ_PATTERN, ANY_CODE, 1'b0);
    send_word(REQ_PATTERN, STAR_CODE, 1'b0);
    send_word(REQ_PATTERN, 8'h63, 1'b0);
    send_word(REQ_TEXT, 8'h61, 1'b1);
    send_word(REQ_TEXT, ANY_CODE, 1'b0);
    send_word(REQ_TEXT, 8'h63, 1'b0);
    send_word(REQ_TEXT, 8'h78, 1'b0);
    send_word(REQ_TEXT, 8'h63, 1'b0);
    // any-byte wildcard
    send_word(REQ_PATTERN, ANY_CODE, 1'b1);
    send_word(REQ_TEXT, ANY_CODE, 1'b1);
    send_word(REQ_TEXT, 8'h55, 1'b1);
    send_word(REQ_TEXT, 8'hAA, 1'b0);

    while (words_sent < 900)
      send_random_sequence();
    @(negedge clk);
    req_valid = 1'b0;

    waited = 0;
    while (sb.pending() > 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (sb.pending() > 0) begin
      $display("%0t: %0d result words never arrived", $time, sb.pending());
      sb.errors++;
    end
    repeat (10) @(posedge clk);
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
